@@ sv/swle_pkg.sv @@
// Shared types and constants for the size-weighted LRU evictor.
// Holds the input and result beat structs, the action, result and ALU codes.
// No dependencies.
package swle_pkg;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_SHRINK = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    KIND_DONE   = 2'd0,
    KIND_EVICT  = 2'd1,
    KIND_REJECT = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ALU_EQ      = 2'd0,
    ALU_GT      = 2'd1,
    ALU_SUB_SAT = 2'd2,
    ALU_ADD     = 2'd3
  } alu_op_e;

  localparam logic [31:0] BUDGET_RESET = 32'd1048576;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] entry_id;
    logic [31:0] entry_size;
    logic [31:0] limit;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] evicted_id;
    logic [31:0] evicted_size;
    logic [31:0] usage;
    logic        last;
  } out_t;

endpackage

@@ sv/swle_alu.sv @@
// Shared arithmetic and compare unit of the evictor sequencer.
// Depends on swle_pkg for the operation codes.
module swle_alu import swle_pkg::*; #(
  parameter int unsigned AW = 32
) (
  input  alu_op_e         op_i,
  input  logic [AW-1:0]   a_i,
  input  logic [AW-1:0]   b_i,
  output logic [AW-1:0]   res_o,
  output logic            flag_o
);

  logic          a_lt_b;
  logic [AW-1:0] diff;

  assign a_lt_b = (a_i < b_i);
  assign diff   = a_i - b_i;

  always_comb begin
    res_o  = '0;
    flag_o = 1'b0;
    unique case (op_i)
      ALU_EQ: begin
        flag_o = (a_i == b_i);
      end
      ALU_GT: begin
        flag_o = (a_i > b_i);
      end
      ALU_SUB_SAT: begin
        // A subtrahend larger than the minuend clamps to zero.
        res_o = a_lt_b ? '0 : diff;
      end
      ALU_ADD: begin
        res_o = a_i + b_i;
      end
    endcase
  end

endmodule

@@ sv/swle_ctrl.sv @@
// Sequencer of the evictor: slot memory, fill count, usage total and the
// step-by-step control around one shared swle_alu. Depends on swle_pkg.
module swle_ctrl import swle_pkg::*; #(
  parameter int unsigned ENTRIES   = 16,
  parameter int unsigned SIZE_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_data_i,
  input  logic [31:0] budget_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output out_t        res_o
);

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned FW = $clog2(ENTRIES + 1);
  localparam int unsigned AW = (SIZE_BITS > 32) ? SIZE_BITS : 32;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SRCH_RD  = 4'd1;
  localparam logic [3:0] S_SRCH_CMP = 4'd2;
  localparam logic [3:0] S_SHIFT_RD = 4'd3;
  localparam logic [3:0] S_SHIFT_WR = 4'd4;
  localparam logic [3:0] S_FRONT    = 4'd5;
  localparam logic [3:0] S_RM_SUB   = 4'd6;
  localparam logic [3:0] S_RM_RD    = 4'd7;
  localparam logic [3:0] S_RM_WR    = 4'd8;
  localparam logic [3:0] S_TARGET   = 4'd9;
  localparam logic [3:0] S_CHECK    = 4'd10;
  localparam logic [3:0] S_EV_RD    = 4'd11;
  localparam logic [3:0] S_EV_SUB   = 4'd12;
  localparam logic [3:0] S_EV_EMIT  = 4'd13;
  localparam logic [3:0] S_DONE     = 4'd14;
  localparam logic [3:0] S_REJECT   = 4'd15;

  logic [3:0]           state_q, state_d;
  logic [1:0]           act_q, act_d;
  logic [15:0]          id_q, id_d;
  logic [SIZE_BITS-1:0] sel_size_q, sel_size_d;
  logic [31:0]          target_q, target_d;
  logic [IW-1:0]        idx_q, idx_d;
  logic [FW-1:0]        fill_q, fill_d;
  logic [SIZE_BITS-1:0] total_q, total_d;
  logic                 miss_q, miss_d;
  logic                 force_q, force_d;

  // Slot memory, slot 0 is the most recently used entry.
  logic [15:0]          mem_id_q   [ENTRIES];
  logic [SIZE_BITS-1:0] mem_size_q [ENTRIES];
  logic [15:0]          rd_id_q;
  logic [SIZE_BITS-1:0] rd_size_q;
  logic                 rd_en, wr_en;
  logic [IW-1:0]        rd_addr, wr_addr;
  logic [15:0]          wr_id;
  logic [SIZE_BITS-1:0] wr_size;

  alu_op_e              alu_op;
  logic [AW-1:0]        alu_a, alu_b, alu_res;
  logic                 alu_flag;

  logic [FW-1:0]        fill_m1, idx_p1;
  logic [IW-1:0]        idx_m1;
  logic [AW-1:0]        size_in_w, total_w, rd_size_w;
  logic [SIZE_BITS-1:0] size_in;
  logic [31:0]          usage32;

  assign fill_m1   = fill_q - FW'(1);
  assign idx_p1    = FW'(idx_q) + FW'(1);
  assign idx_m1    = idx_q - IW'(1);
  assign size_in_w = AW'(in_data_i.entry_size);
  assign size_in   = size_in_w[SIZE_BITS-1:0];
  assign total_w   = AW'(total_q);
  assign rd_size_w = AW'(rd_size_q);
  assign usage32   = total_w[31:0];

  swle_alu #(.AW(AW)) u_alu (
    .op_i   (alu_op),
    .a_i    (alu_a),
    .b_i    (alu_b),
    .res_o  (alu_res),
    .flag_o (alu_flag)
  );

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_id_q[wr_addr]   <= wr_id;
      mem_size_q[wr_addr] <= wr_size;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_id_q   <= mem_id_q[rd_addr];
      rd_size_q <= mem_size_q[rd_addr];
    end
  end

  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    id_d        = id_q;
    sel_size_d  = sel_size_q;
    target_d    = target_q;
    idx_d       = idx_q;
    fill_d      = fill_q;
    total_d     = total_q;
    miss_d      = miss_q;
    force_d     = force_q;
    rd_en       = 1'b0;
    rd_addr     = idx_q;
    wr_en       = 1'b0;
    wr_addr     = idx_q;
    wr_id       = rd_id_q;
    wr_size     = rd_size_q;
    alu_op      = ALU_EQ;
    alu_a       = '0;
    alu_b       = '0;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '{kind: KIND_DONE, evicted_id: '0, evicted_size: '0,
                    usage: usage32, last: 1'b1};

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          act_d      = in_data_i.action;
          id_d       = in_data_i.entry_id;
          sel_size_d = size_in;
          miss_d     = 1'b0;
          force_d    = 1'b0;
          idx_d      = '0;
          unique case (in_data_i.action)
            ACT_ADD: begin
              if (size_in == '0) begin
                state_d = S_REJECT;
              end else if (fill_q == '0) begin
                miss_d  = 1'b1;
                state_d = S_TARGET;
              end else begin
                state_d = S_SRCH_RD;
              end
            end
            ACT_REMOVE: begin
              state_d = (fill_q == '0) ? S_DONE : S_SRCH_RD;
            end
            ACT_SHRINK: begin
              target_d = in_data_i.limit;
              state_d  = S_CHECK;
            end
            default: begin
              state_d = S_REJECT;
            end
          endcase
        end
      end
      S_SRCH_RD: begin
        rd_en   = 1'b1;
        state_d = S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        alu_op = ALU_EQ;
        alu_a  = AW'(rd_id_q);
        alu_b  = AW'(id_q);
        if (alu_flag) begin
          sel_size_d = rd_size_q;
          if (act_q == ACT_ADD) begin
            state_d = (idx_q == '0) ? S_DONE : S_SHIFT_RD;
          end else begin
            state_d = S_RM_SUB;
          end
        end else if (idx_p1 == fill_q) begin
          if (act_q == ACT_ADD) begin
            miss_d  = 1'b1;
            state_d = S_TARGET;
          end else begin
            state_d = S_DONE;
          end
        end else begin
          idx_d   = idx_p1[IW-1:0];
          state_d = S_SRCH_RD;
        end
      end
      S_SHIFT_RD: begin
        rd_en   = 1'b1;
        rd_addr = idx_m1;
        state_d = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        wr_en   = 1'b1;
        idx_d   = idx_m1;
        state_d = (idx_m1 == '0) ? S_FRONT : S_SHIFT_RD;
      end
      S_FRONT: begin
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_id   = id_q;
        wr_size = sel_size_q;
        if (miss_q) begin
          alu_op  = ALU_ADD;
          alu_a   = total_w;
          alu_b   = AW'(sel_size_q);
          total_d = alu_res[SIZE_BITS-1:0];
          fill_d  = fill_q + FW'(1);
        end
        state_d = S_DONE;
      end
      S_RM_SUB: begin
        alu_op  = ALU_SUB_SAT;
        alu_a   = total_w;
        alu_b   = AW'(sel_size_q);
        total_d = alu_res[SIZE_BITS-1:0];
        fill_d  = fill_m1;
        state_d = (idx_p1 < fill_q) ? S_RM_RD : S_DONE;
      end
      S_RM_RD: begin
        rd_en   = 1'b1;
        rd_addr = idx_p1[IW-1:0];
        state_d = S_RM_WR;
      end
      S_RM_WR: begin
        wr_en = 1'b1;
        if (idx_p1 < fill_q) begin
          idx_d   = idx_p1[IW-1:0];
          state_d = S_RM_RD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_TARGET: begin
        alu_op   = ALU_SUB_SAT;
        alu_a    = AW'(budget_i);
        alu_b    = AW'(sel_size_q);
        target_d = alu_res[31:0];
        state_d  = S_CHECK;
      end
      S_CHECK: begin
        alu_op = ALU_GT;
        alu_a  = total_w;
        alu_b  = AW'(target_q);
        if (fill_q != '0 && alu_flag) begin
          state_d = S_EV_RD;
        end else if (act_q == ACT_SHRINK) begin
          state_d = S_DONE;
        end else if (fill_q == FW'(ENTRIES)) begin
          force_d = 1'b1;
          state_d = S_EV_RD;
        end else if (fill_q == '0) begin
          state_d = S_FRONT;
        end else begin
          idx_d   = fill_q[IW-1:0];
          state_d = S_SHIFT_RD;
        end
      end
      S_EV_RD: begin
        rd_en   = 1'b1;
        rd_addr = fill_m1[IW-1:0];
        state_d = S_EV_SUB;
      end
      S_EV_SUB: begin
        alu_op  = ALU_SUB_SAT;
        alu_a   = total_w;
        alu_b   = rd_size_w;
        total_d = alu_res[SIZE_BITS-1:0];
        fill_d  = fill_m1;
        state_d = S_EV_EMIT;
      end
      S_EV_EMIT: begin
        res_valid_o = 1'b1;
        res_o       = '{kind: KIND_EVICT, evicted_id: rd_id_q,
                        evicted_size: rd_size_w[31:0], usage: usage32, last: 1'b0};
        if (res_ready_i) begin
          if (force_q) begin
            // With ENTRIES above one, the full-table eviction always leaves at least one entry.
            force_d = 1'b0;
            idx_d   = fill_q[IW-1:0];
            state_d = S_SHIFT_RD;
          end else begin
            state_d = S_CHECK;
          end
        end
      end
      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      S_REJECT: begin
        res_valid_o = 1'b1;
        res_o.kind  = KIND_REJECT;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
      total_q <= '0;
      miss_q  <= 1'b0;
      force_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      total_q <= total_d;
      miss_q  <= miss_d;
      force_q <= force_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q      <= act_d;
    id_q       <= id_d;
    sel_size_q <= sel_size_d;
    target_q   <= target_d;
    idx_q      <= idx_d;
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(ENTRIES))
    else $error("fill count exceeds the table depth");

  a_evict_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EV_RD) |-> (fill_q != '0))
    else $error("eviction started on an empty table");

  a_shift_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT_RD) |-> (idx_q != '0))
    else $error("shift step reads below slot 0");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FRONT && miss_q) |=> (fill_q == $past(fill_q) + FW'(1)))
    else $error("insert did not grow the fill count");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !res_valid_o)
    else $error("result offered while waiting for a request");

endmodule

@@ sv/size_weighted_lru_evictor.sv @@
// Top level of the size-weighted LRU evictor: budget register, result
// register and the swle_ctrl sequencer. Depends on swle_pkg, swle_ctrl.
//
// Usage. A request beat on the in channel carries an action (add or touch,
// remove, shrink), an entry id, an entry size and a shrink limit. Each
// request answers with zero or more eviction beats on the out channel,
// then one final beat (done or reject) with last set; every beat carries
// the resident usage after it. The cfg channel writes the budget and is
// always ready; write it only while no request is in flight.
//
// Timing. Requests are handled one at a time and in_ready_o is low until
// the final beat has been handed to the result register. A lookup visits
// the slots one after another, each read through the registered read port
// of the slot memory and then compared. Each eviction runs through the
// usage compare, the slot read, the saturating subtract and the result
// handover. Moving slots to reorder the list reads and then writes each
// slot moved.
//
// Reset clears the table (fill count zero), the usage and the result valid
// flag, and loads the budget with 1048576. When the receiver stalls,
// the result register holds its beat and the sequencer waits on the next.
module size_weighted_lru_evictor import swle_pkg::*; #(
  parameter int unsigned ENTRIES   = 16,
  parameter int unsigned SIZE_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);

  logic [31:0] budget_q;
  logic        out_valid_q;
  out_t        out_data_q;
  logic        res_valid;
  logic        res_ready;
  out_t        res;

  // The budget register takes a write in any cycle.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      budget_q <= BUDGET_RESET;
    end else if (cfg_valid_i) begin
      budget_q <= cfg_data_i;
    end
  end

  swle_ctrl #(
    .ENTRIES   (ENTRIES),
    .SIZE_BITS (SIZE_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .budget_i    (budget_q),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // The result register frees up in the same cycle its beat is taken, so
  // the register can take one beat per cycle while out_ready_i holds.
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
